/* hdl/nch_pkg.sv */
// Shared types and constants for the normalized clip histogram unit.
// No dependencies; every other file in hdl/ but nch_ram imports this package.
package nch_pkg;

   localparam int HIST_BINS       = 256;
   localparam int HIST_COUNT_BITS = 32;

   localparam int REG_BITS       = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int FRAC_BITS      = 16;
   localparam int HEIGHT_BITS    = FRAC_BITS + 1;
   localparam int DIV_STEPS      = FRAC_BITS;
   localparam int STEP_BITS      = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_BEGIN = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIN_SCALE  = 1'd1;

   localparam logic [REG_BITS-1:0]    SCALE_RESET = 32'h0001_0000;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_ONE  = 17'h1_0000;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] sample;
      logic [7:0]         bin_select;
   } req_payload_type;

   typedef struct packed {
      logic [31:0]            bin_count;
      logic [31:0]            peak_count;
      logic [HEIGHT_BITS-1:0] height;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic calc_diff;
      logic calc_mul;
      logic calc_bin;
      logic rd_sel;
      logic upd_bin;
      logic load_count;
      logic div_step;
      logic load_rsp;
      logic clear_step;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic div_last;
   } ctl_sts_type;

endpackage

/* hdl/nch_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/nch_datapath.sv */
// Datapath: configuration registers, bin mapping, bin memory, peak tracking,
// iterative height divider and result register. Depends on nch_pkg, nch_ram.
module nch_datapath #(
   parameter int BINS       = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [nch_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [nch_pkg::REG_BITS-1:0]          csr_wdata,
   input  nch_pkg::req_payload_type              req_data,
   input  nch_pkg::ctl_cmd_type                  cmd,
   output nch_pkg::ctl_sts_type                  sts,
   output nch_pkg::rsp_payload_type              rsp_data
);
   import nch_pkg::*;

   localparam int IDX_W = $clog2(BINS);
   localparam int XW    = COUNT_BITS + 32;

   logic [REG_BITS-1:0]   clip_ff, clip_in;
   logic [REG_BITS-1:0]   scale_ff, scale_in;
   req_payload_type       req_ff;
   logic [31:0]           ud_ff;
   logic                  nonpos_ff;
   logic [47:0]           prod_hi_ff, prod_lo_ff;
   logic [IDX_W-1:0]      bin_ff, bin_in;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0] tallest_ff, tallest_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [FRAC_BITS-1:0]  quot_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  zero_peak_ff, full_ff;
   rsp_payload_type       rsp_ff, rsp_in;

   logic signed [32:0]    diff;
   logic [48:0]           lo_rounded;
   logic [48:0]           scaled_sum;
   logic [32:0]           bin_raw;
   logic [31:0]           sel_wide;
   logic                  sel_in_range;
   logic [IDX_W-1:0]      sel_idx;
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data, inc_count;
   logic [COUNT_BITS:0]   rem_dbl, peak_ext, rem_sub;
   logic                  rem_ge;
   logic                  round_up;
   logic [HEIGHT_BITS-1:0] height;
   logic [XW-1:0]         count_ext, peak_wide;

   // configuration writes
   always_comb begin
      clip_in  = clip_ff;
      scale_in = scale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CLIP_BEGIN: clip_in  = csr_wdata;
            CSR_BIN_SCALE:  scale_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // bin mapping: exact 33-bit difference, split 32x16 products, round half up
   assign diff       = {req_ff.sample[31], req_ff.sample} - {clip_ff[31], clip_ff};
   assign lo_rounded = {1'b0, prod_lo_ff} + 49'h0_8000_0000;
   assign scaled_sum = {1'b0, prod_hi_ff} + (lo_rounded >> 16);
   assign bin_raw    = scaled_sum[48:16];

   always_comb begin
      if (nonpos_ff) begin
         bin_in = '0;
      end else if (bin_raw > 33'(BINS - 1)) begin
         bin_in = IDX_W'(BINS - 1);
      end else begin
         bin_in = bin_raw[IDX_W-1:0];
      end
   end

   // bin read for op read
   assign sel_wide     = 32'(req_ff.bin_select);
   assign sel_in_range = sel_wide < 32'(BINS);
   assign sel_idx      = sel_wide[IDX_W-1:0];

   // bin memory
   assign inc_count   = (&ram_rd_data) ? ram_rd_data : ram_rd_data + COUNT_BITS'(1);
   assign ram_wr_en   = cmd.upd_bin || cmd.clear_step;
   assign ram_wr_addr = cmd.clear_step ? sweep_ff : bin_ff;
   assign ram_wr_data = cmd.clear_step ? '0 : inc_count;
   assign ram_rd_addr = cmd.rd_sel ? sel_idx : bin_ff;

   nch_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(BINS)
   ) u_bins (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // sweep address wraps back to zero after the last bin
   assign sts.clear_last = sweep_ff == IDX_W'(BINS - 1);
   assign sweep_in       = sts.clear_last ? '0 : sweep_ff + IDX_W'(1);

   always_comb begin
      tallest_in = tallest_ff;
      if (cmd.clear_step) begin
         tallest_in = '0;
      end else if (cmd.upd_bin && inc_count > tallest_ff) begin
         tallest_in = inc_count;
      end
   end

   // restoring divider, one quotient bit per step
   assign count_in = sel_in_range ? ram_rd_data : '0;
   assign rem_dbl  = {rem_ff, 1'b0};
   assign peak_ext = {1'b0, tallest_ff};
   assign rem_ge   = rem_dbl >= peak_ext;
   assign rem_sub  = rem_dbl - peak_ext;
   assign rem_in   = rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_dbl[COUNT_BITS-1:0];
   assign sts.div_last = step_ff == STEP_BITS'(DIV_STEPS - 1);

   assign round_up = rem_ff >= (tallest_ff - rem_ff);

   always_comb begin
      if (zero_peak_ff) begin
         height = '0;
      end else if (full_ff) begin
         height = HEIGHT_ONE;
      end else begin
         height = {1'b0, quot_ff} + HEIGHT_BITS'(round_up);
      end
   end

   assign count_ext         = XW'(count_ff);
   assign peak_wide         = XW'(tallest_ff);
   assign rsp_in.bin_count  = count_ext[31:0];
   assign rsp_in.peak_count = peak_wide[31:0];
   assign rsp_in.height     = height;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff    <= '0;
         scale_ff   <= SCALE_RESET;
         sweep_ff   <= '0;
         step_ff    <= '0;
         tallest_ff <= '0;
      end else begin
         clip_ff    <= clip_in;
         scale_ff   <= scale_in;
         tallest_ff <= tallest_in;
         if (cmd.clear_step) begin
            sweep_ff <= sweep_in;
         end
         if (cmd.div_step) begin
            step_ff <= step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.calc_diff) begin
         ud_ff     <= diff[31:0];
         nonpos_ff <= diff[32] || (diff == '0);
      end
      if (cmd.calc_mul) begin
         prod_hi_ff <= ud_ff * scale_ff[31:16];
         prod_lo_ff <= ud_ff * scale_ff[15:0];
      end
      if (cmd.calc_bin) begin
         bin_ff <= bin_in;
      end
      if (cmd.load_count) begin
         count_ff     <= count_in;
         rem_ff       <= count_in;
         quot_ff      <= '0;
         full_ff      <= count_in >= tallest_ff;
         zero_peak_ff <= tallest_ff == '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[FRAC_BITS-2:0], rem_ge};
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* hdl/nch_ctrl.sv */
// Controller: sequences sample, read and clear operations over the datapath,
// owns the input stall and the result valid. Depends on nch_pkg.
module nch_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  nch_pkg::ctl_sts_type sts,
   output nch_pkg::ctl_cmd_type cmd
);
   import nch_pkg::*;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_DIFF,
      S_MUL,
      S_BIN,
      S_RDBIN,
      S_UPD,
      S_RDSEL,
      S_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_held;

   assign rsp_held  = rsp_valid_ff && rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_held;
      case (state_ff)
         S_SWEEP: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_op)
                  OP_ADD:   state_in = S_DIFF;
                  OP_READ:  state_in = S_RDSEL;
                  OP_CLEAR: state_in = S_SWEEP;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.calc_mul = 1'b1;
            state_in     = S_BIN;
         end
         S_BIN: begin
            cmd.calc_bin = 1'b1;
            state_in     = S_RDBIN;
         end
         S_RDBIN: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd_bin = 1'b1;
            state_in    = S_IDLE;
         end
         S_RDSEL: begin
            cmd.rd_sel = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_count = 1'b1;
            state_in       = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the previous result has been taken
            if (!rsp_held) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register reloaded while a result was stalled");

   a_sweep_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP && sts.clear_last) |=> state_ff == S_IDLE)
      else $error("clear sweep did not return to idle");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> (state_ff == S_DIV && !sts.div_last))
      else $error("divider step counter not at zero when division starts");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result valid raised outside the finish step");

endmodule

/* hdl/normalized_clip_histogram_unit.sv */
// Top level of the normalized clip histogram: controller plus datapath.
// Depends on nch_pkg, nch_ctrl, nch_datapath (which holds nch_ram).
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  req_data  (op, sample, bin_select)
//   rsp_      out         rsp_valid / rsp_stall  rsp_data  (bin_count, peak_count, height)
//   csr_      in          csr_wr_en              csr_index, csr_wdata
//
// A sample op runs these steps from transfer to the next possible transfer:
//   difference, two 32x16 products, round/clamp, bin memory read, write back.
// A read op runs memory read, count load, 16 divider steps (one quotient bit
//   each), finish; it waits at finish only while an older result is stalled.
// A clear op sweeps the bin memory: one bin memory entry is zeroed per cycle.
// After reset the same clearing pass runs with req_stall high;
//   csr writes are taken during it.
// A waiting result blocks new transfers on the request side only once the
//   next read reaches its finish step; samples and clears pass meanwhile.
module normalized_clip_histogram_unit #(
   parameter int BINS       = nch_pkg::HIST_BINS,
   parameter int COUNT_BITS = nch_pkg::HIST_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [nch_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nch_pkg::REG_BITS-1:0]       csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  nch_pkg::req_payload_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output nch_pkg::rsp_payload_type           rsp_data
);
   import nch_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencing: one operation in flight, request stalled outside idle
   nch_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_data.op),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // arithmetic, bin memory and result register
   nch_datapath #(
      .BINS      (BINS),
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

/* dv/tb_normalized_clip_histogram_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for normalized_clip_histogram_unit: a directed table, then random phases
// over several clip/scale settings, every bin report checked against an in-bench histogram or a typed-in report.
// Depends on nch_pkg and the RTL top normalized_clip_histogram_unit.
module tb_normalized_clip_histogram_unit;
   import nch_pkg::*;

   // op code 3 is unused by the block: it must be swallowed with no report
   localparam logic [1:0] OP_IDLE_CODE = 2'd3;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int DIRECTED_ROWS   = 24;
   localparam int REPORT_LIMIT    = 10;
   // a clear walks every bin once; leave room for that plus the pipeline
   localparam int SETTLE_CYCLES   = HIST_BINS + 40;
   localparam int CYCLE_LIMIT     = 1_000_000;

   // one row of the directed table; when fixed is set the report is typed in
   typedef struct packed {
      logic [1:0]             op;
      logic [31:0]            sample;
      logic [7:0]             bin_select;
      logic                   fixed;
      logic [31:0]            bin_count;
      logic [31:0]            peak_count;
      logic [HEIGHT_BITS-1:0] height;
   } directed_row_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CLIP_BEGIN;
   logic [REG_BITS-1:0]       csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_data;

   normalized_clip_histogram_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Histogram model: bins, tallest count and the two registers
   // ------------------------------------------------------------------
   logic [31:0]     hist_bins [HIST_BINS];
   logic [31:0]     hist_peak;
   logic [31:0]     model_clip_begin;
   logic [31:0]     model_bin_scale;
   logic [7:0]      recent_bin;
   rsp_payload_type pending_reports [$];

   int send_gap_pct;
   int recv_stall_pct;
   int mismatch_count  = 0;
   int reports_checked = 0;
   int items_sent      = 0;
   int settings_used   = 0;
   int cycle_count     = 0;

   // Directed table. Typed reports use the reset registers (clip 0, scale 1.0),
   // so a sample's bin is simply its value rounded half up, clamped to 0..255.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty histogram: peak 0 gives height 0
      {OP_READ,      32'h0000_0000, 8'd0,   1'b1, 32'd0, 32'd0, 17'd0},
      // largest sample clamps to the top bin, smallest to bin zero
      {OP_ADD,       32'h7FFF_FFFF, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_ADD,       32'h8000_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_ADD,       32'h0000_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_READ,      32'h0000_0000, 8'd255, 1'b1, 32'd1, 32'd2, 17'd32768},
      {OP_READ,      32'h0000_0000, 8'd0,   1'b1, 32'd2, 32'd2, HEIGHT_ONE},
      // 1.5 rounds up to bin 2, just below 1.5 stays in bin 1
      {OP_ADD,       32'h0001_8000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_ADD,       32'h0001_7FFF, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_READ,      32'h0000_0000, 8'd2,   1'b1, 32'd1, 32'd2, 17'd32768},
      {OP_READ,      32'h0000_0000, 8'd1,   1'b1, 32'd1, 32'd2, 17'd32768},
      // unused op with every payload bit set: no report, no change
      {OP_IDLE_CODE, 32'hFFFF_FFFF, 8'd255, 1'b0, 32'd0, 32'd0, 17'd0},
      {OP_READ,      32'h0000_0000, 8'd3,   1'b1, 32'd0, 32'd2, 17'd0},
      {OP_CLEAR,     32'h0000_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_READ,      32'h0000_0000, 8'd0,   1'b1, 32'd0, 32'd0, 17'd0},
      {OP_ADD,       32'h0001_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_ADD,       32'h0001_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_ADD,       32'h0001_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_ADD,       32'h0000_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_READ,      32'h0000_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_READ,      32'h0000_0000, 8'd1,   1'b1, 32'd3, 32'd3, HEIGHT_ONE},
      {OP_READ,      32'h0000_0000, 8'd255, 1'b1, 32'd0, 32'd3, 17'd0},
      // exactly one half rounds up into bin 1
      {OP_ADD,       32'h0000_8000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0},
      {OP_READ,      32'h0000_0000, 8'd1,   1'b1, 32'd4, 32'd4, HEIGHT_ONE},
      {OP_READ,      32'h0000_0000, 8'd0,   1'b0, 32'd0, 32'd0, 17'd0}
   };

   function automatic void reset_histogram_model();
      foreach (hist_bins[i]) hist_bins[i] = '0;
      hist_peak        = '0;
      model_clip_begin = '0;
      model_bin_scale  = SCALE_RESET;
      recent_bin       = '0;
   endfunction

   // Bin of a sample: round half up of (sample - clip_begin) * bin_scale,
   // taken exactly (33-bit difference, 65-bit product), clamped to the top bin.
   function automatic logic [7:0] map_sample_to_bin(input logic [31:0] sample);
      logic signed [32:0] diff;
      logic [64:0]        scaled;
      logic [32:0]        slot;
      diff = $signed({sample[31], sample}) - $signed({model_clip_begin[31], model_clip_begin});
      if (diff <= 0) begin
         return 8'd0;
      end
      // a positive difference is below 2^32, so its low 32 bits hold it whole
      scaled = 65'(diff[31:0]) * 65'(model_bin_scale) + 65'h0_8000_0000;
      slot   = scaled[64:32];
      return (slot > 33'(HIST_BINS - 1)) ? 8'(HIST_BINS - 1) : slot[7:0];
   endfunction

   // count / peak in Q1.16, round half up; zero when the histogram is empty
   function automatic logic [HEIGHT_BITS-1:0] relative_height(input logic [31:0] count,
                                                              input logic [31:0] peak);
      logic [47:0] scaled, quo, rem;
      if (peak == '0) begin
         return '0;
      end
      if (count >= peak) begin
         return HEIGHT_ONE;
      end
      scaled = {count, 16'h0000};
      quo    = scaled / 48'(peak);
      rem    = scaled % 48'(peak);
      if ((rem << 1) >= 48'(peak)) begin
         quo = quo + 1;
      end
      return quo[HEIGHT_BITS-1:0];
   endfunction

   // Apply one accepted transfer to the model; a read yields a bin report.
   function automatic bit advance_histogram(input req_payload_type item,
                                            output rsp_payload_type report);
      logic [7:0] slot;
      bit         has_report;
      has_report = 1'b0;
      report     = '0;
      case (item.op)
         OP_ADD: begin
            slot       = map_sample_to_bin(item.sample);
            recent_bin = slot;
            // counts stick at all ones
            if (hist_bins[slot] != '1) begin
               hist_bins[slot] = hist_bins[slot] + 1;
            end
            if (hist_bins[slot] > hist_peak) begin
               hist_peak = hist_bins[slot];
            end
         end
         OP_READ: begin
            report.bin_count  = hist_bins[item.bin_select];
            report.peak_count = hist_peak;
            report.height     = relative_height(hist_bins[item.bin_select], hist_peak);
            has_report        = 1'b1;
         end
         OP_CLEAR: begin
            foreach (hist_bins[i]) hist_bins[i] = '0;
            hist_peak = '0;
         end
         default: begin
         end
      endcase
      return has_report;
   endfunction

   // ------------------------------------------------------------------
   // Request side: random gaps, then hold valid and payload until transfer
   // ------------------------------------------------------------------
   task automatic drive_request(input req_payload_type item, input bit fixed,
                                input rsp_payload_type fixed_report);
      rsp_payload_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      // transfer happened at this edge: advance the model
      if (advance_histogram(item, predicted)) begin
         pending_reports.push_back(fixed ? fixed_report : predicted);
      end
      items_sent++;
   endtask

   // Drop valid, wait out every report, then give a clear or add time to finish.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on back-to-back edges; enable stays high across them.
   task automatic program_registers(input logic [31:0] clip, input logic [31:0] scale);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CLIP_BEGIN;
      csr_wdata <= clip;
      @(posedge clock);
      model_clip_begin = clip;
      csr_index <= CSR_BIN_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      model_bin_scale = scale;
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Mostly adds inside the clip window so the bins fill unevenly, reads often
   // aimed at the last bin hit, rare clears and the odd unused op.
   function automatic req_payload_type random_request(input logic [31:0] span);
      req_payload_type item;
      int unsigned     pick;
      int unsigned     where;
      pick            = $urandom_range(99);
      where           = $urandom_range(9);
      item.sample     = $urandom;
      item.bin_select = 8'($urandom_range(255));
      if (pick < 66) begin
         item.op = OP_ADD;
         if (where < 7) begin
            item.sample = model_clip_begin + $urandom_range(span);
         end else if (where < 9) begin
            item.sample = model_clip_begin + $urandom_range(32'h0004_0000) - 32'h0002_0000;
         end
      end else if (pick < 90) begin
         item.op = OP_READ;
         if (where < 5) begin
            item.bin_select = recent_bin;
         end
      end else if (pick < 92) begin
         item.op = OP_CLEAR;
      end else begin
         item.op = OP_IDLE_CODE;
      end
      return item;
   endfunction

   // ------------------------------------------------------------------
   // Result side: random stall, check each transfer against the oldest report
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected bin report count=%0d peak=%0d height=%0d",
                        $time, rsp_data.bin_count, rsp_data.peak_count, rsp_data.height);
            end
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_data.bin_count !== want.bin_count ||
                rsp_data.peak_count !== want.peak_count ||
                rsp_data.height !== want.height) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: bin report mismatch expected %0d/%0d/%0d got %0d/%0d/%0d",
                           $time, want.bin_count, want.peak_count, want.height,
                           rsp_data.bin_count, rsp_data.peak_count, rsp_data.height);
               end
            end
         end
      end
   end

   // Hard stop if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, pending_reports.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: reset, directed table, then random phases over register settings
   // ------------------------------------------------------------------
   initial begin
      req_payload_type  item;
      rsp_payload_type  fixed_report;
      logic [31:0]      clip;
      logic [31:0]      scale;
      logic [31:0]      span;
      logic [63:0]      scale_wide;

      reset_histogram_model();
      send_gap_pct   = 26;
      recv_stall_pct = 77;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part runs on the reset register values
      foreach (directed_rows[r]) begin
         item.op                 = directed_rows[r].op;
         item.sample             = directed_rows[r].sample;
         item.bin_select         = directed_rows[r].bin_select;
         fixed_report.bin_count  = directed_rows[r].bin_count;
         fixed_report.peak_count = directed_rows[r].peak_count;
         fixed_report.height     = directed_rows[r].height;
         drive_request(item, directed_rows[r].fixed, fixed_report);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // receiver sparse first, then sender sparse, then full rate both ways
         if (phase < 4) begin
            send_gap_pct   = 26;
            recv_stall_pct = 77;
         end else if (phase < 7) begin
            send_gap_pct   = 77;
            recv_stall_pct = 26;
         end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end

         case (phase)
            0: begin
               // lowest clip, steepest scale: almost everything lands on top
               clip  = 32'h8000_0000;
               scale = 32'hFFFF_FFFF;
               span  = 32'hFFFF_FFFF;
            end
            1: begin
               // highest clip, zero scale: everything lands in bin zero
               clip  = 32'h7FFF_FFFF;
               scale = 32'h0000_0000;
               span  = 32'hFFFF_FFFF;
            end
            2: begin
               clip  = 32'h0000_0000;
               scale = SCALE_RESET;
               span  = 32'h00FF_0000;
            end
            default: begin
               // random window; scale maps it onto the 255 bin steps
               clip       = $urandom;
               span       = ($urandom >> $urandom_range(23)) | 32'h0000_0100;
               scale_wide = (64'd255 << 32) / 64'(span);
               scale      = (scale_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scale_wide[31:0];
            end
         endcase

         drain_block();
         program_registers(clip, scale);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            drive_request(random_request(span), 1'b0, '0);
         end
      end

      drain_block();
      mismatch_count += pending_reports.size();

      $display("%0d transfers sent across %0d clip/scale settings and the reset values",
               items_sent, settings_used);
      $display("%0d bin reports checked, %0d mismatches", reports_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/nch_pkg.sv
hdl/nch_ram.sv
hdl/nch_datapath.sv
hdl/nch_ctrl.sv
hdl/normalized_clip_histogram_unit.sv
dv/tb_normalized_clip_histogram_unit.sv
